// File: design/u16u8_pkg.sv
// Package with the types, constants and encoding functions of the UTF-16 to UTF-8 converter.
`timescale 1ns / 1ps
package u16u8_pkg;

	localparam int unsigned UNIT_W    = 16;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CP_W      = 21;
	localparam int unsigned CNT_W     = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 16;
	localparam int unsigned MAX_RES   = 6;
	localparam int unsigned RES_W     = 3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_SRC_EXH = 2'd1;
	localparam status_t ST_SRC_ILL = 2'd2;
	localparam status_t ST_TGT_EXH = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_STRICT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

	localparam logic [CNT_W-1:0] CAPACITY_RST = 16'd8000;

	typedef logic [3:0][BYTE_W-1:0] cp_bytes_t;

	function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
		logic [2:0] n;
		if (cp < 21'h80) begin
			n = 3'd1;
		end else if (cp < 21'h800) begin
			n = 3'd2;
		end else if (cp < 21'h10000) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	function automatic cp_bytes_t utf8_enc(input logic [CP_W-1:0] cp, input logic [2:0] n);
		cp_bytes_t b;
		b = '0;
		case (n)
			3'd1: begin
				b[0] = {1'b0, cp[6:0]};
			end
			3'd2: begin
				b[0] = {3'b110, cp[10:6]};
				b[1] = {2'b10, cp[5:0]};
			end
			3'd3: begin
				b[0] = {4'b1110, cp[15:12]};
				b[1] = {2'b10, cp[11:6]};
				b[2] = {2'b10, cp[5:0]};
			end
			default: begin
				b[0] = {5'b11110, cp[20:18]};
				b[1] = {2'b10, cp[17:12]};
				b[2] = {2'b10, cp[11:6]};
				b[3] = {2'b10, cp[5:0]};
			end
		endcase
		return b;
	endfunction

endpackage

// File: design/u16u8_if.sv
// Channel interfaces of the UTF-16 to UTF-8 converter: code units, result items and register writes.
`timescale 1ns / 1ps

interface u16u8_unit_if import u16u8_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] code_unit;
	modport source (output valid, output code_unit, input ready);
	modport sink   (input valid, input code_unit, output ready);
endinterface

interface u16u8_byte_if import u16u8_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_of_run;
	logic              string_done;
	status_t           status;
	modport source (output valid, output out_byte, output last_of_run, output string_done,
		output status, input ready);
	modport sink   (input valid, input out_byte, input last_of_run, input string_done,
		input status, output ready);
endinterface

interface u16u8_cfg_if import u16u8_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/utf16_to_utf8_converter_top.sv
// Top level of the UTF-16 to UTF-8 converter.
//
// Channel   Role   Payload
// unit_ch   sink   code_unit (16 bits)
// byte_ch   source out_byte (8), last_of_run, string_done, status (2)
// cfg_ch    sink   index (1: 0 strict_mode, 1 output_capacity), data (16)
//
// A code unit is decoded and encoded in the cycle it is accepted, and its 0 to 6 results are
// loaded into a result buffer that drains one result per cycle on byte_ch while byte_ch.ready is high.
// A new unit is accepted when the buffer is empty or its last result leaves in the same cycle.
// A stall on byte_ch holds the buffer and blocks unit_ch. Register writes are always taken.
// Reset clears the string state and loads the register reset values.
`timescale 1ns / 1ps
module utf16_to_utf8_converter_top
	import u16u8_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	u16u8_unit_if.sink   unit_ch,
	u16u8_byte_if.source byte_ch,
	u16u8_cfg_if.sink    cfg_ch
);

	logic             strict_q;
	logic [CNT_W-1:0] capacity_q;
	logic [9:0]       pend_high_q;
	logic             pend_valid_q;
	logic [CNT_W-1:0] written_q;
	logic             halted_q;
	status_t          err_q;

	logic [MAX_RES-1:0][BYTE_W-1:0] buf_s1;
	logic                           done_s1;
	status_t                        stat_s1;
	logic [RES_W-1:0]               rem_q;
	logic [RES_W-1:0]               rd_q;

	logic [UNIT_W-1:0] u;
	logic              in_fire;
	logic              out_fire;
	logic              is_high;
	logic              is_low;

	logic [9:0]       pend_high_d;
	logic             pend_valid_d;
	logic [CNT_W-1:0] written_d;
	logic             halted_d;
	status_t          err_d;
	logic             done_d;
	status_t          stat_d;

	logic [CP_W-1:0]  cp_a;
	logic [CP_W-1:0]  cp_b;
	logic [2:0]       n_a;
	logic [2:0]       n_b;
	logic [RES_W-1:0] cnt_a;
	logic [RES_W-1:0] cnt_b;
	logic [CNT_W:0]   sum_a;
	logic [CNT_W:0]   sum_b;
	logic [CNT_W-1:0] written_mid;
	logic             a_ok;
	logic             b_ok;
	logic             fresh;
	cp_bytes_t        enc_a;
	cp_bytes_t        enc_b;
	logic [RES_W-1:0] cnt_d;
	logic [MAX_RES-1:0][BYTE_W-1:0] buf_d;
	logic [RES_W-1:0] slot_b;

	assign u        = unit_ch.code_unit;
	assign in_fire  = unit_ch.valid && unit_ch.ready;
	assign out_fire = byte_ch.valid && byte_ch.ready;
	assign is_high  = (u >= 16'hD800) && (u <= 16'hDBFF);
	assign is_low   = (u >= 16'hDC00) && (u <= 16'hDFFF);

	assign unit_ch.ready = (rem_q == '0) || ((rem_q == RES_W'(1)) && byte_ch.ready);
	assign cfg_ch.ready  = 1'b1;

	assign byte_ch.valid       = (rem_q != '0);
	assign byte_ch.out_byte    = buf_s1[rd_q];
	assign byte_ch.last_of_run = (rem_q == RES_W'(1));
	assign byte_ch.string_done = done_s1;
	assign byte_ch.status      = stat_s1;

	assign cp_a = pend_valid_q && is_low ?
		CP_W'(21'h10000 + {pend_high_q, 10'd0} + {11'd0, u[9:0]}) :
		{5'd0, 6'b110110, pend_high_q};
	assign cp_b  = {5'd0, u};
	assign n_a   = utf8_len(cp_a);
	assign n_b   = utf8_len(cp_b);
	assign enc_a = utf8_enc(cp_a, n_a);
	assign enc_b = utf8_enc(cp_b, n_b);
	assign sum_a = {1'b0, written_q} + {14'd0, n_a};

	always_comb begin
		pend_high_d  = pend_high_q;
		pend_valid_d = pend_valid_q;
		written_d    = written_q;
		halted_d     = halted_q;
		err_d        = err_q;
		done_d       = 1'b0;
		stat_d       = ST_OK;
		a_ok         = 1'b0;
		b_ok         = 1'b0;
		fresh        = 1'b0;
		written_mid  = written_q;
		sum_b        = '0;
		if (u == '0) begin
			done_d       = 1'b1;
			stat_d       = halted_q ? err_q : (pend_valid_q ? ST_SRC_EXH : ST_OK);
			pend_high_d  = '0;
			pend_valid_d = 1'b0;
			written_d    = '0;
			halted_d     = 1'b0;
			err_d        = ST_OK;
		end else if (!halted_q) begin
			fresh = 1'b1;
			if (pend_valid_q) begin
				pend_valid_d = 1'b0;
				pend_high_d  = '0;
				if (!is_low && strict_q) begin
					halted_d = 1'b1;
					err_d    = ST_SRC_ILL;
					fresh    = 1'b0;
				end else begin
					if (is_low) begin
						fresh = 1'b0;
					end
					if (sum_a > {1'b0, capacity_q}) begin
						halted_d = 1'b1;
						err_d    = ST_TGT_EXH;
						fresh    = 1'b0;
					end else begin
						a_ok        = 1'b1;
						written_mid = sum_a[CNT_W-1:0];
						written_d   = written_mid;
					end
				end
			end
			if (fresh) begin
				sum_b = {1'b0, written_mid} + {14'd0, n_b};
				if (is_high) begin
					pend_valid_d = 1'b1;
					pend_high_d  = u[9:0];
				end else if (is_low && strict_q) begin
					halted_d = 1'b1;
					err_d    = ST_SRC_ILL;
				end else if (sum_b > {1'b0, capacity_q}) begin
					halted_d = 1'b1;
					err_d    = ST_TGT_EXH;
				end else begin
					b_ok      = 1'b1;
					written_d = sum_b[CNT_W-1:0];
				end
			end
		end
	end

	assign cnt_a = a_ok ? n_a : '0;
	assign cnt_b = b_ok ? n_b : '0;
	assign cnt_d = done_d ? RES_W'(1) : RES_W'(cnt_a + cnt_b);

	always_comb begin
		for (int j = 0; j < MAX_RES; j++) begin
			slot_b   = RES_W'(j) - cnt_a;
			buf_d[j] = '0;
			if (!done_d) begin
				if (RES_W'(j) < cnt_a) begin
					buf_d[j] = enc_a[2'(j)];
				end else begin
					buf_d[j] = enc_b[slot_b[1:0]];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q   <= 1'b0;
			capacity_q <= CAPACITY_RST;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				REG_STRICT: begin
					strict_q <= cfg_ch.data[0];
				end
				REG_CAPACITY: begin
					capacity_q <= cfg_ch.data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_high_q  <= '0;
			pend_valid_q <= 1'b0;
			written_q    <= '0;
			halted_q     <= 1'b0;
			err_q        <= ST_OK;
			rem_q        <= '0;
			rd_q         <= '0;
		end else if (in_fire) begin
			pend_high_q  <= pend_high_d;
			pend_valid_q <= pend_valid_d;
			written_q    <= written_d;
			halted_q     <= halted_d;
			err_q        <= err_d;
			rem_q        <= cnt_d;
			rd_q         <= '0;
		end else if (out_fire) begin
			rem_q <= rem_q - RES_W'(1);
			rd_q  <= rd_q + RES_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			buf_s1  <= buf_d;
			done_s1 <= done_d;
			stat_s1 <= stat_d;
		end
	end

endmodule
